// ===== hw/rtl/mfqd_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the dispatcher.
package mfqd_pkg;

    localparam int MAX_PROCS  = 16;
    localparam int MAX_LEVELS = 4;

    localparam int PID_W     = $clog2(MAX_PROCS);
    localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int MEM_AW    = LVL_W + PID_W;
    localparam int CLK_W     = 21;
    localparam int CLK_IDX_W = $clog2(CLK_W);
    localparam int TIME_W    = 16;
    localparam int ID_W      = 8;
    localparam int LCNT_W    = 3;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVELS = 3'd0,
        CFG_BOOST  = 3'd1,
        CFG_SLICE0 = 3'd2,
        CFG_SLICE1 = 3'd3,
        CFG_SLICE2 = 3'd4,
        CFG_SLICE3 = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic clr;
        logic adm_start;
        logic adm_step;
        logic mod_start;
        logic mod_step;
        logic bst_start;
        logic bst_rd;
        logic bst_wr;
        logic sel;
        logic tick;
        logic calc;
        logic emit;
        logic emit_all;
    } t_cmd;

    typedef struct packed {
        logic adm_last;
        logic boost_due;
        logic mod_last;
        logic mod_zero;
        logic bst_empty;
        logic bst_last;
        logic any_ready;
        logic none_left;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/mfqd_ctrl.sv =====
// Sequencing state machine of the dispatcher: drives the datapath one step at a time.
module mfqd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_op,
    input  mfqd_pkg::t_sts    i_sts,
    output logic              o_in_stall,
    output mfqd_pkg::t_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_ADMIT   = 10'b00_0000_0010,
        S_MOD     = 10'b00_0000_0100,
        S_MODCHK  = 10'b00_0000_1000,
        S_BST_RD  = 10'b00_0001_0000,
        S_BST_WR  = 10'b00_0010_0000,
        S_SELECT  = 10'b00_0100_0000,
        S_CALC    = 10'b00_1000_0000,
        S_EMIT    = 10'b01_0000_0000,
        S_ALLDONE = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (mfqd_pkg::t_opcode'(i_op))
                        mfqd_pkg::CMD_LOAD:  o_cmd.load = 1'b1;
                        mfqd_pkg::CMD_CLEAR: o_cmd.clr  = 1'b1;
                        mfqd_pkg::CMD_STEP: begin
                            if (i_sts.none_left) begin
                                n_state = S_ALLDONE;
                            end else begin
                                o_cmd.adm_start = 1'b1;
                                n_state         = S_ADMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADMIT: begin
                o_cmd.adm_step = 1'b1;
                if (i_sts.adm_last) begin
                    if (i_sts.boost_due) begin
                        o_cmd.mod_start = 1'b1;
                        n_state         = S_MOD;
                    end else begin
                        n_state = S_SELECT;
                    end
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) n_state = S_MODCHK;
            end
            S_MODCHK: begin
                if (i_sts.mod_zero && (mfqd_pkg::MAX_LEVELS > 1)) begin
                    o_cmd.bst_start = 1'b1;
                    n_state         = S_BST_RD;
                end else begin
                    n_state = S_SELECT;
                end
            end
            S_BST_RD: begin
                o_cmd.bst_rd = 1'b1;
                if (!i_sts.bst_empty) begin
                    n_state = S_BST_WR;
                end else if (i_sts.bst_last) begin
                    n_state = S_SELECT;
                end
            end
            S_BST_WR: begin
                o_cmd.bst_wr = 1'b1;
                n_state      = S_BST_RD;
            end
            S_SELECT: begin
                if (i_sts.any_ready) begin
                    o_cmd.sel = 1'b1;
                    n_state   = S_CALC;
                end else begin
                    // Nothing runnable: let one time unit pass and admit again.
                    o_cmd.tick = 1'b1;
                    n_state    = S_ADMIT;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_ALLDONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_all = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/mfqd_dp.sv =====
// Datapath of the dispatcher: registers, process table, level queues and result register.
module mfqd_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mfqd_pkg::t_cmd                        i_cmd,
    output mfqd_pkg::t_sts                        o_sts,
    input  logic [mfqd_pkg::ID_W-1:0]             i_proc_id,
    input  logic [mfqd_pkg::TIME_W-1:0]           i_arrive_at,
    input  logic [mfqd_pkg::TIME_W-1:0]           i_burst_len,
    input  logic                                  i_cfg_we,
    input  logic [mfqd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mfqd_pkg::TIME_W-1:0]           i_cfg_data,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic [mfqd_pkg::CLK_W-1:0]            o_event_time,
    output logic [mfqd_pkg::ID_W-1:0]             o_run_pid,
    output logic [mfqd_pkg::TIME_W-1:0]           o_run_length,
    output logic                                  o_first_run,
    output logic                                  o_finished,
    output logic                                  o_drained
);

    localparam int NP  = mfqd_pkg::MAX_PROCS;
    localparam int NL  = mfqd_pkg::MAX_LEVELS;
    localparam int PW  = mfqd_pkg::PID_W;
    localparam int LW  = mfqd_pkg::LVL_W;
    localparam int CW  = mfqd_pkg::CNT_W;
    localparam int TW  = mfqd_pkg::TIME_W;
    localparam int KW  = mfqd_pkg::CLK_W;
    localparam int MEM_DEPTH = 2 ** mfqd_pkg::MEM_AW;

    // Configuration registers.
    logic [mfqd_pkg::LCNT_W-1:0] r_lvl_cnt;
    logic [TW-1:0]               r_boost;
    logic [TW-1:0]               r_slice [NL];

    // Process table.
    logic [TW-1:0]               r_arr   [NP];
    logic [TW-1:0]               r_rem   [NP];
    logic [mfqd_pkg::ID_W-1:0]   r_ident [NP];
    logic [NP-1:0]               r_started;
    logic [NP-1:0]               r_queued;

    // Level queues share one memory, addressed by {level, slot}.
    logic [PW-1:0]               r_mem [MEM_DEPTH];
    logic [PW-1:0]               r_rd_data;
    logic [PW-1:0]               r_head [NL];
    logic [PW-1:0]               r_tail [NL];
    logic [CW-1:0]               r_fill [NL];

    logic [KW-1:0]               r_clock;
    logic [CW-1:0]               r_loaded;
    logic [CW-1:0]               r_unfin;
    logic [PW-1:0]               r_scan;
    logic [TW-1:0]               r_mod_rem;
    logic [mfqd_pkg::CLK_IDX_W-1:0] r_mod_cnt;
    logic [LW-1:0]               r_bq;
    logic [LW-1:0]               r_sel;
    logic [TW-1:0]               r_run;

    logic                        r_out_valid;
    logic [KW-1:0]               r_event_time;
    logic [mfqd_pkg::ID_W-1:0]   r_run_pid;
    logic [TW-1:0]               r_run_length;
    logic                        r_first_run;
    logic                        r_finished;
    logic                        r_drained;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(NP - 1)) ? '0 : p + PW'(1);
    endfunction

    logic [PW-1:0]               w_addr;
    logic [TW-1:0]               w_arr;
    logic [TW-1:0]               w_rem;
    logic                        w_admit;
    logic                        w_adm_last;
    logic                        w_any;
    logic [LW-1:0]               w_pick;
    logic [TW-1:0]               w_slice;
    logic [TW-1:0]               w_new_rem;
    logic                        w_fin;
    logic [LW-1:0]               w_last;
    logic [LW:0]                 w_nxt;
    logic [LW-1:0]               w_nq;
    logic [TW:0]                 w_mod_t;
    logic                        w_mod_ge;
    logic                        w_out_free;
    logic                        w_push_run;
    logic                        w_mem_we;
    logic [mfqd_pkg::MEM_AW-1:0] w_mem_waddr;
    logic [PW-1:0]               w_mem_wdata;
    logic                        w_mem_re;
    logic [mfqd_pkg::MEM_AW-1:0] w_mem_raddr;

    // One table read port: the scan index while admitting, the dispatched entry otherwise.
    assign w_addr     = i_cmd.adm_step ? r_scan : r_rd_data;
    assign w_arr      = r_arr[w_addr];
    assign w_rem      = r_rem[w_addr];
    assign w_adm_last = (CW'(r_scan) + CW'(1)) >= r_loaded;
    assign w_admit    = i_cmd.adm_step && (CW'(r_scan) < r_loaded) && !r_queued[w_addr]
                        && (KW'(w_arr) <= r_clock) && (w_rem != '0);

    always_comb begin
        w_any  = 1'b0;
        w_pick = '0;
        for (int q = NL - 1; q >= 0; q--) begin
            if (r_fill[q] != '0) begin
                w_any  = 1'b1;
                w_pick = LW'(q);
            end
        end
    end

    assign w_slice   = (r_slice[r_sel] == '0) ? TW'(1) : r_slice[r_sel];
    assign w_new_rem = w_rem - r_run;
    assign w_fin     = (w_new_rem == '0);

    always_comb begin
        if (r_lvl_cnt == '0) begin
            w_last = '0;
        end else if (r_lvl_cnt > mfqd_pkg::LCNT_W'(NL)) begin
            w_last = LW'(NL - 1);
        end else begin
            w_last = LW'(r_lvl_cnt - mfqd_pkg::LCNT_W'(1));
        end
    end
    assign w_nxt = {1'b0, r_sel} + (LW + 1)'(1);
    assign w_nq  = (w_nxt > {1'b0, w_last}) ? w_last : w_nxt[LW-1:0];

    // Restoring remainder of the time by the boost period, one time bit a cycle.
    assign w_mod_t  = {r_mod_rem, r_clock[r_mod_cnt]};
    assign w_mod_ge = w_mod_t >= {1'b0, r_boost};

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_push_run = i_cmd.emit && !w_fin;

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = '0;
        w_mem_wdata = r_rd_data;
        if (w_admit) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = {LW'(0), r_tail[0]};
            w_mem_wdata = r_scan;
        end else if (i_cmd.bst_wr) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = {LW'(0), r_tail[0]};
        end else if (w_push_run) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = {w_nq, r_tail[w_nq]};
        end
    end

    always_comb begin
        w_mem_re    = 1'b0;
        w_mem_raddr = {r_bq, r_head[r_bq]};
        if (i_cmd.bst_rd && (r_fill[r_bq] != '0)) begin
            w_mem_re = 1'b1;
        end else if (i_cmd.sel) begin
            w_mem_re    = 1'b1;
            w_mem_raddr = {w_pick, r_head[w_pick]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_waddr] <= w_mem_wdata;
        if (w_mem_re) r_rd_data <= r_mem[w_mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_cnt <= mfqd_pkg::LCNT_W'(3);
            r_boost   <= '0;
            r_slice[0] <= TW'(2);
            r_slice[1] <= TW'(4);
            r_slice[2] <= TW'(8);
            r_slice[3] <= TW'(16);
        end else if (i_cfg_we) begin
            case (mfqd_pkg::t_cfg_idx'(i_cfg_index))
                mfqd_pkg::CFG_LEVELS: r_lvl_cnt  <= i_cfg_data[mfqd_pkg::LCNT_W-1:0];
                mfqd_pkg::CFG_BOOST:  r_boost    <= i_cfg_data;
                mfqd_pkg::CFG_SLICE0: r_slice[0] <= i_cfg_data;
                mfqd_pkg::CFG_SLICE1: r_slice[1] <= i_cfg_data;
                mfqd_pkg::CFG_SLICE2: r_slice[2] <= i_cfg_data;
                mfqd_pkg::CFG_SLICE3: r_slice[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Table payload carries no reset; entries are read only after a load.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_loaded < CW'(NP))) begin
            r_arr[r_loaded[PW-1:0]]   <= i_arrive_at;
            r_rem[r_loaded[PW-1:0]]   <= i_burst_len;
            r_ident[r_loaded[PW-1:0]] <= i_proc_id;
        end else if (i_cmd.emit) begin
            r_rem[w_addr] <= w_new_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_started <= '0;
            r_queued  <= '0;
            r_clock   <= '0;
            r_loaded  <= '0;
            r_unfin   <= '0;
            for (int q = 0; q < NL; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
                r_fill[q] <= '0;
            end
        end else begin
            if (i_cmd.load && (r_loaded < CW'(NP))) begin
                r_started[r_loaded[PW-1:0]] <= 1'b0;
                r_queued[r_loaded[PW-1:0]]  <= 1'b0;
                r_loaded <= r_loaded + CW'(1);
                if (i_burst_len != '0) r_unfin <= r_unfin + CW'(1);
            end
            if (w_admit) begin
                r_queued[r_scan] <= 1'b1;
            end
            if (w_admit || i_cmd.bst_wr) begin
                r_tail[0] <= ptr_inc(r_tail[0]);
                r_fill[0] <= r_fill[0] + CW'(1);
            end
            if (i_cmd.bst_rd) begin
                if (r_fill[r_bq] != '0) begin
                    r_head[r_bq] <= ptr_inc(r_head[r_bq]);
                    r_fill[r_bq] <= r_fill[r_bq] - CW'(1);
                end else begin
                    r_head[r_bq] <= '0;
                    r_tail[r_bq] <= '0;
                end
            end
            if (i_cmd.sel) begin
                r_head[w_pick] <= ptr_inc(r_head[w_pick]);
                r_fill[w_pick] <= r_fill[w_pick] - CW'(1);
            end
            if (i_cmd.tick) begin
                r_clock <= r_clock + KW'(1);
            end
            if (i_cmd.emit) begin
                r_clock             <= r_clock + KW'(r_run);
                r_started[r_rd_data] <= 1'b1;
                r_queued[r_rd_data]  <= !w_fin;
                if (w_fin) begin
                    r_unfin <= r_unfin - CW'(1);
                end else begin
                    r_tail[w_nq] <= ptr_inc(r_tail[w_nq]);
                    r_fill[w_nq] <= r_fill[w_nq] + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.adm_start || i_cmd.tick) begin
            r_scan <= '0;
        end else if (i_cmd.adm_step) begin
            r_scan <= r_scan + PW'(1);
        end
        if (i_cmd.mod_start) begin
            r_mod_rem <= '0;
            r_mod_cnt <= mfqd_pkg::CLK_IDX_W'(KW - 1);
        end else if (i_cmd.mod_step) begin
            r_mod_rem <= w_mod_ge ? TW'(w_mod_t - {1'b0, r_boost}) : w_mod_t[TW-1:0];
            r_mod_cnt <= r_mod_cnt - mfqd_pkg::CLK_IDX_W'(1);
        end
        if (i_cmd.bst_start) begin
            r_bq <= LW'(1);
        end else if (i_cmd.bst_rd && (r_fill[r_bq] == '0)) begin
            r_bq <= r_bq + LW'(1);
        end
        if (i_cmd.sel) r_sel <= w_pick;
        if (i_cmd.calc) r_run <= (w_rem < w_slice) ? w_rem : w_slice;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_all) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_event_time <= r_clock;
            r_run_pid    <= r_ident[w_addr];
            r_run_length <= r_run;
            r_first_run  <= !r_started[w_addr];
            r_finished   <= w_fin;
            r_drained    <= 1'b0;
        end else if (i_cmd.emit_all) begin
            r_event_time <= r_clock;
            r_run_pid    <= '0;
            r_run_length <= '0;
            r_first_run  <= 1'b0;
            r_finished   <= 1'b0;
            r_drained    <= 1'b1;
        end
    end

    assign o_sts.adm_last  = w_adm_last;
    assign o_sts.boost_due = (r_boost != '0) && (r_clock != '0);
    assign o_sts.mod_last  = (r_mod_cnt == '0);
    assign o_sts.mod_zero  = (r_mod_rem == '0);
    assign o_sts.bst_empty = (r_fill[r_bq] == '0);
    assign o_sts.bst_last  = (r_bq == LW'(NL - 1));
    assign o_sts.any_ready = w_any;
    assign o_sts.none_left = (r_unfin == '0);
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_event_time = r_event_time;
    assign o_run_pid    = r_run_pid;
    assign o_run_length = r_run_length;
    assign o_first_run  = r_first_run;
    assign o_finished   = r_finished;
    assign o_drained    = r_drained;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[0] <= CW'(NP))
        else $error("level 0 queue holds more entries than the table");

    a_unfin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unfin <= r_loaded)
        else $error("more unfinished processes than loaded ones");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.emit_all) |-> (!r_out_valid || !i_out_stall))
        else $error("result written over a beat still waiting");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.emit_all) |=> r_out_valid)
        else $error("written result not presented");

endmodule

// ===== hw/rtl/multilevel_feedback_queue_dispatcher.sv =====
// Multilevel feedback queue dispatcher: load, clear and step commands in, one dispatch per step out.
// A load, a clear or an unknown command is done without leaving idle. A step runs passes of the
// scheduler: each pass scans the loaded table for arrivals at one entry per cycle, and when boost
// is enabled and the time is nonzero it computes the time modulo the boost period bit-serially;
// when that is zero it then checks each lower level and moves its entries to level 0 one by one.
// A pass that finds every level empty advances time by one and starts again, so waiting for a
// late arrival costs a full pass per idle time unit. After its pass a dispatch goes through the
// select and calc states and an emit that waits for a free output; a step with nothing left
// goes straight to reporting that all is done. Only one command is worked on at a time.
module multilevel_feedback_queue_dispatcher (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_cmd,
    input  logic [mfqd_pkg::ID_W-1:0]             i_proc_id,
    input  logic [mfqd_pkg::TIME_W-1:0]           i_arrive_at,
    input  logic [mfqd_pkg::TIME_W-1:0]           i_burst_len,
    input  logic                                  i_cfg_we,
    input  logic [mfqd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mfqd_pkg::TIME_W-1:0]           i_cfg_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [mfqd_pkg::CLK_W-1:0]            o_event_time,
    output logic [mfqd_pkg::ID_W-1:0]             o_run_pid,
    output logic [mfqd_pkg::TIME_W-1:0]           o_run_length,
    output logic                                  o_first_run,
    output logic                                  o_finished,
    output logic                                  o_drained
);

    mfqd_pkg::t_cmd w_cmd;
    mfqd_pkg::t_sts w_sts;

    mfqd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_cmd),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    mfqd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_proc_id    (i_proc_id),
        .i_arrive_at  (i_arrive_at),
        .i_burst_len  (i_burst_len),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_event_time (o_event_time),
        .o_run_pid    (o_run_pid),
        .o_run_length (o_run_length),
        .o_first_run  (o_first_run),
        .o_finished   (o_finished),
        .o_drained    (o_drained)
    );

endmodule

// ===== bench/multilevel_feedback_queue_dispatcher_tb.sv =====
// Self-checking testbench for the multilevel feedback queue dispatcher.
module multilevel_feedback_queue_dispatcher_tb;

    localparam int MAX_PROCS  = mfqd_pkg::MAX_PROCS;
    localparam int MAX_LEVELS = mfqd_pkg::MAX_LEVELS;
    localparam int CLK_W      = mfqd_pkg::CLK_W;
    localparam int ID_W       = mfqd_pkg::ID_W;
    localparam int TIME_W     = mfqd_pkg::TIME_W;
    localparam int CFG_IDX_W  = mfqd_pkg::CFG_IDX_W;

    typedef struct packed {
        logic [CLK_W-1:0]  event_time;
        logic [ID_W-1:0]   run_pid;
        logic [TIME_W-1:0] run_length;
        logic              first_run;
        logic              finished;
        logic              drained;
    } t_dispatch;

    // Tracks the scheduler state and holds the dispatches still owed by the block.
    class dispatch_scoreboard;
        int unsigned level_count, boost_period;
        int unsigned slices[MAX_LEVELS];
        int unsigned arrival[MAX_PROCS], remaining[MAX_PROCS];
        int unsigned ident[MAX_PROCS];
        bit started[MAX_PROCS], queued[MAX_PROCS];
        int unsigned fifo_mem[MAX_LEVELS][MAX_PROCS];
        int unsigned head[MAX_LEVELS], tail[MAX_LEVELS], fill[MAX_LEVELS];
        int unsigned sim_clock, loaded, unfinished;
        t_dispatch owed[$];
        int mismatches;

        function new();
            level_count = 3;
            boost_period = 0;
            slices[0] = 2; slices[1] = 4; slices[2] = 8; slices[3] = 16;
            mismatches = 0;
            clear_table();
        endfunction

        function void clear_table();
            for (int i = 0; i < MAX_PROCS; i++) begin
                started[i] = 0;
                queued[i] = 0;
            end
            for (int q = 0; q < MAX_LEVELS; q++) begin
                head[q] = 0; tail[q] = 0; fill[q] = 0;
            end
            sim_clock = 0;
            loaded = 0;
            unfinished = 0;
        endfunction

        function void write_reg(mfqd_pkg::t_cfg_idx idx, int unsigned val);
            case (idx)
                mfqd_pkg::CFG_LEVELS: level_count = val & 7;
                mfqd_pkg::CFG_BOOST:  boost_period = val & 16'hFFFF;
                mfqd_pkg::CFG_SLICE0: slices[0] = val & 16'hFFFF;
                mfqd_pkg::CFG_SLICE1: slices[1] = val & 16'hFFFF;
                mfqd_pkg::CFG_SLICE2: slices[2] = val & 16'hFFFF;
                mfqd_pkg::CFG_SLICE3: slices[3] = val & 16'hFFFF;
                default: ;
            endcase
        endfunction

        function void push(int unsigned q, int unsigned idx);
            if (q >= MAX_LEVELS || fill[q] >= MAX_PROCS) return;
            fifo_mem[q][tail[q] % MAX_PROCS] = idx;
            tail[q] = (tail[q] + 1) % MAX_PROCS;
            fill[q]++;
        endfunction

        function int unsigned pop(int unsigned q);
            int unsigned idx;
            idx = fifo_mem[q][head[q] % MAX_PROCS];
            head[q] = (head[q] + 1) % MAX_PROCS;
            fill[q]--;
            return idx % MAX_PROCS;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_beat(mfqd_pkg::t_opcode cmd, int unsigned pid, int unsigned arr,
                                int unsigned burst);
            t_dispatch d;
            int unsigned sel, idx, slc, run, last, nq, lvls;
            if (cmd == mfqd_pkg::CMD_LOAD) begin
                if (loaded >= MAX_PROCS) return;
                ident[loaded] = pid;
                arrival[loaded] = arr;
                remaining[loaded] = burst;
                started[loaded] = 0;
                queued[loaded] = 0;
                if (burst != 0) unfinished++;
                loaded++;
                return;
            end
            if (cmd == mfqd_pkg::CMD_CLEAR) begin
                clear_table();
                return;
            end
            if (cmd != mfqd_pkg::CMD_STEP) return;
            d = '0;
            d.event_time = CLK_W'(sim_clock);
            d.drained = 1'b1;
            if (unfinished == 0) begin
                owed.push_back(d);
                return;
            end
            while (1) begin
                for (int i = 0; i < loaded; i++)
                    if (!queued[i] && arrival[i] <= sim_clock && remaining[i] != 0) begin
                        push(0, i);
                        queued[i] = 1;
                    end
                if (boost_period != 0 && sim_clock != 0 && sim_clock % boost_period == 0)
                    for (int q = 1; q < MAX_LEVELS; q++) begin
                        while (fill[q] != 0) begin
                            idx = pop(q);
                            if (remaining[idx] != 0) push(0, idx);
                            else queued[idx] = 0;
                        end
                        head[q] = 0;
                        tail[q] = 0;
                    end
                sel = MAX_LEVELS;
                for (int q = MAX_LEVELS - 1; q >= 0; q--)
                    if (fill[q] != 0) sel = q;
                if (sel == MAX_LEVELS) begin
                    sim_clock = (sim_clock + 1) & 21'h1FFFFF;
                    continue;
                end
                idx = pop(sel);
                queued[idx] = 0;
                if (remaining[idx] == 0) continue;
                slc = (slices[sel] == 0) ? 1 : slices[sel];
                run = (remaining[idx] < slc) ? remaining[idx] : slc;
                d = '0;
                d.event_time = CLK_W'(sim_clock);
                d.run_pid    = ID_W'(ident[idx]);
                d.run_length = TIME_W'(run);
                d.first_run  = !started[idx];
                started[idx] = 1;
                sim_clock = (sim_clock + run) & 21'h1FFFFF;
                remaining[idx] -= run;
                if (remaining[idx] == 0) begin
                    unfinished--;
                    d.finished = 1'b1;
                end else begin
                    lvls = (level_count == 0) ? 1 :
                           (level_count > MAX_LEVELS) ? MAX_LEVELS : level_count;
                    last = lvls - 1;
                    nq = (sel + 1 > last) ? last : sel + 1;
                    push(nq, idx);
                    queued[idx] = 1;
                end
                owed.push_back(d);
                return;
            end
        endfunction

        function void check_result(t_dispatch got);
            t_dispatch want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected dispatch: time %0d pid %0d len %0d",
                             got.event_time, got.run_pid, got.run_length);
                return;
            end
            want = owed.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Dispatch mismatch: expected t=%0d pid=%0d len=%0d f=%0b fin=%0b done=%0b",
                             want.event_time, want.run_pid, want.run_length, want.first_run,
                             want.finished, want.drained);
                    $display("                   got      t=%0d pid=%0d len=%0d f=%0b fin=%0b done=%0b",
                             got.event_time, got.run_pid, got.run_length, got.first_run,
                             got.finished, got.drained);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_in_valid = 0;
    logic                 o_in_stall;
    logic [1:0]           i_cmd = 0;
    logic [ID_W-1:0]      i_proc_id = 0;
    logic [TIME_W-1:0]    i_arrive_at = 0;
    logic [TIME_W-1:0]    i_burst_len = 0;
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = 0;
    logic [TIME_W-1:0]    i_cfg_data = 0;
    logic                 o_out_valid;
    logic                 i_out_stall = 0;
    logic [CLK_W-1:0]     o_event_time;
    logic [ID_W-1:0]      o_run_pid;
    logic [TIME_W-1:0]    o_run_length;
    logic                 o_first_run, o_finished, o_drained;

    dispatch_scoreboard sb = new();
    int burst_left = 0;
    int beats_sent = 0;

    multilevel_feedback_queue_dispatcher uut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_beat(mfqd_pkg::t_opcode'(i_cmd), i_proc_id, i_arrive_at, i_burst_len);
            if (o_out_valid && !i_out_stall)
                sb.check_result('{o_event_time, o_run_pid, o_run_length, o_first_run,
                                  o_finished, o_drained});
        end
    end

    // Receiver back-pressure: a randomly drawn mode sets the stall pattern.
    int stall_mode = 0;
    int stall_cnt = 0;
    always @(negedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            2: i_out_stall <= (stall_cnt % 16) < 9;
            3: i_out_stall <= ($urandom_range(0, 5) != 0);
            default: i_out_stall <= 1'b0;
        endcase
    end

    task automatic send(mfqd_pkg::t_opcode cmd, int unsigned pid = 0, int unsigned arr = 0,
                        int unsigned burst = 0);
        @(negedge i_clk);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_cmd <= cmd;
        i_proc_id <= ID_W'(pid);
        i_arrive_at <= TIME_W'(arr);
        i_burst_len <= TIME_W'(burst);
        i_in_valid <= 1'b1;
        beats_sent++;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Waits until every owed dispatch has come back and the block has gone quiet.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(mfqd_pkg::t_cfg_idx idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= TIME_W'(val);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int unsigned pick_slice();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 65535;
            3: return $urandom_range(0, 65535);
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    task automatic retune();
        int unsigned v;
        mfqd_pkg::t_cfg_idx idx;
        idx = mfqd_pkg::t_cfg_idx'($urandom_range(0, 5));
        if (idx == mfqd_pkg::CFG_LEVELS) v = $urandom_range(0, 65535);
        else if (idx == mfqd_pkg::CFG_BOOST)
            case ($urandom_range(0, 4))
                0: v = 0;
                1: v = 1;
                2: v = 65535;
                3: v = $urandom_range(0, 65535);
                default: v = $urandom_range(2, 40);
            endcase
        else v = pick_slice();
        write_reg(idx, v);
    endtask

    task automatic run_job_set();
        int n, steps;
        int unsigned arr, burst, base;
        bit big_ok, cleared;
        cleared = 1'b0;
        if ($urandom_range(0, 3) != 0) begin
            send(mfqd_pkg::CMD_CLEAR);
            cleared = 1'b1;
        end
        // The time restarts at zero after a clear, whether or not the beat is noted yet.
        base = cleared ? 0 : sb.sim_clock;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 8);
        big_ok = sb.slices[0] >= 1024 && sb.slices[1] >= 1024 &&
                 sb.slices[2] >= 1024 && sb.slices[3] >= 1024;
        for (int i = 0; i < n; i++) begin
            arr = $urandom_range(0, base + 20);
            if (arr > 65535) arr = $urandom_range(0, 65535);
            if ($urandom_range(0, 11) == 0) burst = 0;
            else if (big_ok && $urandom_range(0, 3) == 0) burst = $urandom_range(1, 65535);
            else burst = $urandom_range(1, 24);
            send(mfqd_pkg::CMD_LOAD, $urandom_range(0, 255), arr, burst);
            if ($urandom_range(0, 15) == 0)
                send(mfqd_pkg::CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
        end
        steps = $urandom_range(2, 40);
        for (int i = 0; i < steps; i++) send(mfqd_pkg::CMD_STEP);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, zero burst, unknown command, extremes.
        send(mfqd_pkg::CMD_STEP);
        send(mfqd_pkg::CMD_LOAD, 0, 0, 0);
        send(mfqd_pkg::CMD_LOAD, 255, 3, 5);
        send(mfqd_pkg::CMD_LOAD, 8'hAA, 0, 1);
        send(mfqd_pkg::CMD_NONE, 8'h55, 16'hFFFF, 16'hFFFF);
        repeat (5) send(mfqd_pkg::CMD_STEP);
        settle();
        write_reg(mfqd_pkg::CFG_LEVELS, 4);
        write_reg(mfqd_pkg::CFG_BOOST, 0);
        write_reg(mfqd_pkg::CFG_SLICE0, 65535);
        write_reg(mfqd_pkg::CFG_SLICE1, 65535);
        write_reg(mfqd_pkg::CFG_SLICE2, 0);
        write_reg(mfqd_pkg::CFG_SLICE3, 65535);
        send(mfqd_pkg::CMD_CLEAR);
        send(mfqd_pkg::CMD_LOAD, 8'h55, 0, 65535);
        send(mfqd_pkg::CMD_STEP);
        send(mfqd_pkg::CMD_LOAD, 8'hFF, 65535, 1);
        send(mfqd_pkg::CMD_STEP);
        send(mfqd_pkg::CMD_STEP);
        send(mfqd_pkg::CMD_CLEAR);
        send(mfqd_pkg::CMD_LOAD, 8'h0F, 65535, 65535);
        send(mfqd_pkg::CMD_CLEAR);
        send(mfqd_pkg::CMD_STEP);
        settle();
        write_reg(mfqd_pkg::CFG_LEVELS, 0);
        write_reg(mfqd_pkg::CFG_BOOST, 3);
        write_reg(mfqd_pkg::CFG_SLICE0, 1);
        write_reg(mfqd_pkg::CFG_SLICE1, 3);

        while (beats_sent < 1950) begin
            run_job_set();
            if ($urandom_range(0, 2) == 0) begin
                settle();
                repeat ($urandom_range(1, 3)) retune();
            end
        end
        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(12 * 4000000);
        $display("Some tests failed");
        $finish;
    end

endmodule
